/* hdl/loop_playhead_timer_macros.svh */
// ----------------------------------------------------------------------------
// Loop playhead timer assertion macros
// Shared property shorthands, sampled on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef LOOP_PLAYHEAD_TIMER_MACROS_SVH
`define LOOP_PLAYHEAD_TIMER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lpt_pkg.sv */
// ----------------------------------------------------------------------------
// Loop playhead timer package
// Widths, codes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package lpt_pkg;

  localparam int TIME_BITS  = 32;
  localparam int DELTA_W    = 32;
  localparam int LOOP_W     = 32;
  localparam int REP_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int T_W        = TIME_BITS + 2;
  localparam int DIVD_W     = TIME_BITS + 1;
  localparam int LC_W       = DIVD_W + 2;
  localparam int CNT_W      = $clog2(DIVD_W + 1);

  localparam logic [TIME_BITS-1:0] DUR_RESET = TIME_BITS'(65536);

  localparam logic [1:0] MODE_ONCE     = 2'd0;
  localparam logic [1:0] MODE_REPEAT   = 2'd1;
  localparam logic [1:0] MODE_PINGPONG = 2'd2;

  localparam logic [1:0] END_CURV = 2'd0;
  localparam logic [1:0] END_FLAT = 2'd1;
  localparam logic [1:0] END_WRAP = 2'd2;

  localparam logic STEP_ADVANCE = 1'b0;
  localparam logic STEP_RESTART = 1'b1;

  localparam logic signed [REP_W-1:0] REP_INFINITE = {REP_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_DURATION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FSTART   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FEND     = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PREP,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic capture;
    logic load;
    logic div_start;
    logic fix;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic step_valid;
    logic need_div;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

/* hdl/lpt_step_if.sv */
// ----------------------------------------------------------------------------
// Step request channel
// Carries restart or advance requests into the playhead.
// ----------------------------------------------------------------------------
interface lpt_step_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic signed [lpt_pkg::DELTA_W-1:0]  delta_time;

  modport source (output valid, mode, delta_time, input ready);
  modport sink   (input valid, mode, delta_time, output ready);
endinterface

/* hdl/lpt_result_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Sampled clip time, endings and playback flags, one result per step request.
// ----------------------------------------------------------------------------
interface lpt_result_if;
  logic                           valid;
  logic                           ready;
  logic [lpt_pkg::TIME_BITS-1:0]  clip_time;
  logic [1:0]                     ending_start;
  logic [1:0]                     ending_end;
  logic                           is_enabled;
  logic                           is_paused;
  logic                           finished;
  logic                           looped;

  modport source (output valid, clip_time, ending_start, ending_end, is_enabled,
                  is_paused, finished, looped, input ready);
  modport sink   (input valid, clip_time, ending_start, ending_end, is_enabled,
                  is_paused, finished, looped, output ready);
endinterface

/* hdl/lpt_cfg_if.sv */
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index and write data.
// ----------------------------------------------------------------------------
interface lpt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lpt_pkg::CFG_IDX_W-1:0]   addr;
  logic [lpt_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

/* hdl/lpt_div.sv */
// ----------------------------------------------------------------------------
// Playhead divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpt_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [lpt_pkg::DIVD_W-1:0]     dividend,
  input  logic [lpt_pkg::TIME_BITS-1:0]  divisor,
  output logic [lpt_pkg::DIVD_W-1:0]     quotient,
  output logic [lpt_pkg::TIME_BITS-1:0]  remainder,
  output logic                           done
);

  logic [lpt_pkg::CNT_W-1:0]      cnt;
  logic [lpt_pkg::TIME_BITS-1:0]  rem;
  logic [lpt_pkg::DIVD_W-1:0]     quo;
  logic [lpt_pkg::TIME_BITS:0]    rem_sh;
  logic [lpt_pkg::TIME_BITS+1:0]  diff;
  logic                           ge;

  assign rem_sh = {rem, quo[lpt_pkg::DIVD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, divisor};
  assign ge     = ~diff[lpt_pkg::TIME_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= lpt_pkg::CNT_W'(lpt_pkg::DIVD_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == lpt_pkg::CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (cnt != '0) begin
      rem <= ge ? diff[lpt_pkg::TIME_BITS-1:0] : rem_sh[lpt_pkg::TIME_BITS-1:0];
      quo <= {quo[lpt_pkg::DIVD_W-2:0], ge};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

/* hdl/lpt_datapath.sv */
// ----------------------------------------------------------------------------
// Playhead datapath
// Configuration registers, playhead state, wrap folding and the result register.
// ----------------------------------------------------------------------------
`include "loop_playhead_timer_macros.svh"

module lpt_datapath (
  input  logic                clk,
  input  logic                rst,
  lpt_step_if.sink            step,
  lpt_result_if.source        result,
  lpt_cfg_if.sink             cfg,
  input  lpt_pkg::ctrl_cmd_t  cmd,
  output lpt_pkg::dp_status_t status
);

  // Configuration. The duration is stored already forced nonzero.
  logic [lpt_pkg::TIME_BITS-1:0]    dur;
  logic [1:0]                       loop_mode;
  logic signed [lpt_pkg::REP_W-1:0] repeat_limit;
  logic                             clamp_when_done;
  logic                             flat_start;
  logic                             flat_end;

  // Playhead state.
  logic [lpt_pkg::TIME_BITS-1:0] play_time, play_time_next;
  logic [lpt_pkg::LOOP_W-1:0]    loop_counter, loop_counter_next;
  logic                          not_started, not_started_next;
  logic                          enabled_flag, enabled_flag_next;
  logic                          paused_flag, paused_flag_next;
  logic [1:0]                    start_ending, start_ending_next;
  logic [1:0]                    end_ending, end_ending_next;

  // Request and working registers.
  logic                             req_mode;
  logic signed [lpt_pkg::DELTA_W-1:0] req_delta;
  logic signed [lpt_pkg::T_W-1:0]   t_reg;
  logic signed [lpt_pkg::T_W-1:0]   t_mag;
  logic [lpt_pkg::TIME_BITS-1:0]    r_reg;
  logic signed [lpt_pkg::LC_W-1:0]  lc_reg;
  logic signed [lpt_pkg::LC_W-1:0]  lc_base;
  logic signed [lpt_pkg::LC_W-1:0]  rep_ext;
  logic signed [lpt_pkg::LC_W-1:0]  rep_m1;

  logic [lpt_pkg::DIVD_W-1:0]    div_quo;
  logic [lpt_pkg::TIME_BITS-1:0] div_rem;
  logic                          div_done;

  logic                          out_valid;
  logic [lpt_pkg::TIME_BITS-1:0] ct;
  logic [lpt_pkg::TIME_BITS-1:0] sample_now;
  logic                          fin;
  logic                          lp;

  logic pp, once, rep_inf, rep_zero;
  logic d_zero, d_neg, adv;
  logic t_neg, t_ge_dur, wrap_cond, rem_nz, lc_odd;
  logic [3:0] ns_endings;

  function automatic logic [3:0] pick_endings(input logic at_start, input logic at_end,
                                              input logic pingpong, input logic fs,
                                              input logic fe);
    logic [1:0] s;
    logic [1:0] e;
    s = at_start ? {1'b0, fs} : lpt_pkg::END_WRAP;
    e = at_end ? {1'b0, fe} : lpt_pkg::END_WRAP;
    if (pingpong) begin
      s = lpt_pkg::END_FLAT;
      e = lpt_pkg::END_FLAT;
    end
    return {s, e};
  endfunction

  // The user must issue configuration writes only while the block is idle; the block itself does not enforce this.
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      dur             <= lpt_pkg::DUR_RESET;
      loop_mode       <= lpt_pkg::MODE_REPEAT;
      repeat_limit    <= lpt_pkg::REP_INFINITE;
      clamp_when_done <= 1'b0;
      flat_start      <= 1'b0;
      flat_end        <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.addr)
        lpt_pkg::REG_DURATION: begin
          dur <= (cfg.data == '0) ? lpt_pkg::TIME_BITS'(1)
                                  : cfg.data[lpt_pkg::TIME_BITS-1:0];
        end
        lpt_pkg::REG_LOOP:   loop_mode       <= cfg.data[1:0];
        lpt_pkg::REG_REPEAT: repeat_limit    <= $signed(cfg.data[lpt_pkg::REP_W-1:0]);
        lpt_pkg::REG_CLAMP:  clamp_when_done <= cfg.data[0];
        lpt_pkg::REG_FSTART: flat_start      <= cfg.data[0];
        lpt_pkg::REG_FEND:   flat_end        <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign pp       = (loop_mode == lpt_pkg::MODE_PINGPONG);
  assign once     = (loop_mode == lpt_pkg::MODE_ONCE);
  assign rep_inf  = (repeat_limit == lpt_pkg::REP_INFINITE);
  assign rep_zero = (repeat_limit == '0);
  assign rep_ext  = $signed({{(lpt_pkg::LC_W-lpt_pkg::REP_W){repeat_limit[lpt_pkg::REP_W-1]}},
                             repeat_limit});
  assign rep_m1   = rep_ext - lpt_pkg::LC_W'(1);

  // A paused playhead sees a zero step.
  assign d_zero = paused_flag || (req_delta == '0);
  assign d_neg  = req_delta[lpt_pkg::DELTA_W-1];
  assign adv    = (req_mode == lpt_pkg::STEP_ADVANCE) && enabled_flag && !d_zero;

  assign t_neg     = t_reg[lpt_pkg::T_W-1];
  assign t_ge_dur  = t_reg >= $signed({2'b00, dur});
  assign wrap_cond = t_neg || t_ge_dur;
  assign t_mag     = t_neg ? -t_reg : t_reg;

  assign sample_now = (!not_started && pp && loop_counter[0]) ? (dur - play_time) : play_time;

  // Loop count the step starts from; a fresh negative step counts from loop -1.
  assign lc_base = not_started ? (d_neg ? '1 : '0)
                               : $signed({{(lpt_pkg::LC_W-lpt_pkg::LOOP_W){1'b0}},
                                          loop_counter});
  assign rem_nz  = (div_rem != '0);
  assign lc_odd  = not_started ? d_neg : loop_counter[0];

  assign ns_endings = d_neg ? pick_endings(rep_zero, 1'b1, pp, flat_start, flat_end)
                            : pick_endings(1'b1, rep_zero, pp, flat_start, flat_end);

  lpt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (t_mag[lpt_pkg::DIVD_W-1:0]),
    .divisor   (dur),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_mode  <= step.mode;
      req_delta <= step.delta_time;
    end
    if (cmd.load) begin
      t_reg <= $signed({2'b00, play_time})
             + $signed({{(lpt_pkg::T_W-lpt_pkg::DELTA_W){req_delta[lpt_pkg::DELTA_W-1]}},
                        req_delta});
    end
    // Floor division: a negative position with a remainder takes one more loop.
    if (cmd.fix) begin
      lc_reg <= lc_base
              + $signed({{(lpt_pkg::LC_W-lpt_pkg::DIVD_W){1'b0}}, div_quo})
              + $signed({{(lpt_pkg::LC_W-1){1'b0}}, rem_nz & t_neg});
      r_reg  <= (t_neg && rem_nz) ? (dur - div_rem) : div_rem;
    end
  end

  always_comb begin
    play_time_next    = play_time;
    loop_counter_next = loop_counter;
    not_started_next  = not_started;
    enabled_flag_next = enabled_flag;
    paused_flag_next  = paused_flag;
    start_ending_next = start_ending;
    end_ending_next   = end_ending;
    ct                = sample_now;
    fin               = 1'b0;
    lp                = 1'b0;

    if (req_mode == lpt_pkg::STEP_RESTART) begin
      play_time_next    = '0;
      loop_counter_next = '0;
      not_started_next  = 1'b1;
      enabled_flag_next = 1'b1;
      paused_flag_next  = 1'b0;
      ct                = '0;
    end else if (!adv) begin
      ct = sample_now;
    end else if (once) begin
      // The endings and loop count are only set up by the first step.
      if (not_started) begin
        not_started_next  = 1'b0;
        loop_counter_next = '0;
        start_ending_next = {1'b0, flat_start};
        end_ending_next   = {1'b0, flat_end};
      end
      if (t_ge_dur || t_neg) begin
        play_time_next = t_neg ? '0 : dur;
        fin            = 1'b1;
        if (clamp_when_done) paused_flag_next = 1'b1;
        else enabled_flag_next = 1'b0;
      end else begin
        play_time_next = t_reg[lpt_pkg::TIME_BITS-1:0];
      end
      ct = play_time_next;
    end else begin
      if (not_started) begin
        {start_ending_next, end_ending_next} = ns_endings;
      end
      if (!wrap_cond) begin
        play_time_next = t_reg[lpt_pkg::TIME_BITS-1:0];
        ct = (pp && lc_odd) ? (dur - t_reg[lpt_pkg::TIME_BITS-1:0])
                            : t_reg[lpt_pkg::TIME_BITS-1:0];
      end else if (!rep_inf && (lc_reg >= rep_ext)) begin
        // Repetitions used up: clamp to the end reached, loop count untouched.
        play_time_next = d_neg ? '0 : dur;
        fin            = 1'b1;
        if (clamp_when_done) paused_flag_next = 1'b1;
        else enabled_flag_next = 1'b0;
        ct = play_time_next;
      end else begin
        if (!rep_inf && (lc_reg == rep_m1)) begin
          {start_ending_next, end_ending_next} =
            pick_endings(d_neg, !d_neg, pp, flat_start, flat_end);
        end else begin
          {start_ending_next, end_ending_next} =
            pick_endings(1'b0, 1'b0, pp, flat_start, flat_end);
        end
        loop_counter_next = lc_reg[lpt_pkg::LOOP_W-1:0];
        not_started_next  = 1'b0;
        play_time_next    = r_reg;
        lp                = 1'b1;
        ct = (pp && lc_reg[0]) ? (dur - r_reg) : r_reg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      play_time    <= '0;
      loop_counter <= '0;
      not_started  <= 1'b1;
      enabled_flag <= 1'b1;
      paused_flag  <= 1'b0;
      start_ending <= lpt_pkg::END_CURV;
      end_ending   <= lpt_pkg::END_CURV;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.commit) begin
        play_time    <= play_time_next;
        loop_counter <= loop_counter_next;
        not_started  <= not_started_next;
        enabled_flag <= enabled_flag_next;
        paused_flag  <= paused_flag_next;
        start_ending <= start_ending_next;
        end_ending   <= end_ending_next;
        out_valid    <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.clip_time    <= ct;
      result.ending_start <= start_ending_next;
      result.ending_end   <= end_ending_next;
      result.is_enabled   <= enabled_flag_next;
      result.is_paused    <= paused_flag_next;
      result.finished     <= fin;
      result.looped       <= lp;
    end
  end

  assign result.valid = out_valid;
  assign step.ready   = cmd.in_ready && !rst;

  assign status.step_valid = step.valid;
  assign status.need_div   = adv && !once && wrap_cond;
  assign status.div_done   = div_done;
  assign status.out_free   = !out_valid || result.ready;

  `LPT_ASSERT_NOW(a_commit_free, cmd.commit, !out_valid || result.ready, "commit over a held result")
  `LPT_ASSERT_NEXT(a_commit_shows, cmd.commit, out_valid, "committed step produced no result")
  `LPT_ASSERT_NOW(a_pause_needs_enable, 1'b1, !(paused_flag && !enabled_flag), "paused while disabled")
  `LPT_ASSERT_NEXT(a_lc_hold, !cmd.commit, $stable(loop_counter), "loop count moved without a commit")

endmodule

/* hdl/lpt_ctrl.sv */
// ----------------------------------------------------------------------------
// Playhead controller
// Sequences capture, position sum, optional divide, fold and commit.
// ----------------------------------------------------------------------------
`include "loop_playhead_timer_macros.svh"

module lpt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  lpt_pkg::dp_status_t status,
  output lpt_pkg::ctrl_cmd_t  cmd
);

  lpt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      lpt_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (status.step_valid) begin
          cmd.capture = 1'b1;
          state_next  = lpt_pkg::ST_LOAD;
        end
      end
      lpt_pkg::ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = lpt_pkg::ST_PREP;
      end
      lpt_pkg::ST_PREP: begin
        if (status.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = lpt_pkg::ST_DIV;
        end else begin
          state_next = lpt_pkg::ST_DONE;
        end
      end
      lpt_pkg::ST_DIV: begin
        if (status.div_done) begin
          state_next = lpt_pkg::ST_FIX;
        end
      end
      lpt_pkg::ST_FIX: begin
        cmd.fix    = 1'b1;
        state_next = lpt_pkg::ST_DONE;
      end
      lpt_pkg::ST_DONE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = lpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lpt_pkg::ST_IDLE;
      end
    endcase
  end

  `LPT_ASSERT_NOW(a_div_done_in_div, status.div_done, state == lpt_pkg::ST_DIV, "divider finished outside the divide state")

endmodule

/* hdl/loop_playhead_timer.sv */
// A request is captured in idle and passes load and prep to done, where its result
// is registered at commit once no unread result is held. If the position leaves
// the clip in repeat or ping-pong mode, the 33-step restoring divider shared by
// every wrap folds it between prep and a fix state. One request is in flight.
// Reset (synchronous, rst high): configuration and playhead return to defaults,
// the controller goes idle and any pending result is dropped.
// ----------------------------------------------------------------------------
// Loop playhead timer
// Playhead for a looping clip with once, repeat and ping-pong modes.
// ----------------------------------------------------------------------------
module loop_playhead_timer (
  input  logic          clk,
  input  logic          rst,
  lpt_step_if.sink      step,
  lpt_result_if.source  result,
  lpt_cfg_if.sink       cfg
);

  lpt_pkg::ctrl_cmd_t  cmd;
  lpt_pkg::dp_status_t status;

  lpt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  lpt_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .result (result),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status)
  );

endmodule
